### rtl/bhp_pkg.sv
// ----------------------------------------------------------------------------
// bhp_pkg
// Shared constants and types of the biquad high-pass filter: register map,
// coefficient reset values and the delay-line format.
// ----------------------------------------------------------------------------
package bhp_pkg;

  localparam int COEF_BITS       = 32;
  localparam int NUM_COEFS       = 5;
  localparam int DELAY_BITS      = 48;
  localparam int DELAY_FRAC_BITS = DELAY_BITS - 9;
  localparam int ADDR_BITS       = 5;
  localparam int DATA_BITS       = 32;
  localparam int IDX_BITS        = 3;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_FEED_0 = 3'd0,
    REG_FEED_1 = 3'd1,
    REG_FEED_2 = 3'd2,
    REG_BACK_1 = 3'd3,
    REG_BACK_2 = 3'd4
  } coef_idx_e;

  localparam coef_t FEED_0_RST = 32'sd1057637433;
  localparam coef_t FEED_1_RST = -32'sd2115274866;
  localparam coef_t FEED_2_RST = 32'sd1057637433;
  localparam coef_t BACK_1_RST = -32'sd2115033314;
  localparam coef_t BACK_2_RST = 32'sd1041774591;

endpackage

### rtl/bhp_if.sv
// ----------------------------------------------------------------------------
// bhp_in_if / bhp_out_if
// Valid/ready channels carrying audio samples and the block-end flag.
// ----------------------------------------------------------------------------
interface bhp_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_end_in;

  modport source (output valid, sample_in, block_end_in, input ready);
  modport sink   (input valid, sample_in, block_end_in, output ready);
endinterface

interface bhp_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          block_end_out;

  modport source (output valid, sample_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, block_end_out, output ready);
endinterface

### rtl/biquad_highpass_filter_top.sv
// ----------------------------------------------------------------------------
// biquad_highpass_filter_top
// Biquad IIR filter in transposed direct form II with saturating output and
// delay registers; coefficients are written over an APB-style port.
// ----------------------------------------------------------------------------
// One sample is processed at a time: an item is accepted in the idle state and
// then steps through the states M0, A0, Y, M3, A3, A4 and D before it returns
// to idle. The sequence is set by the single sample-by-coefficient multiplier,
// which is used five times per item, plus the rounding and the two delay
// updates that follow it. A finished result sits in an output register, so the
// next item is accepted while it waits; only if that register is still full at
// the end of the next item does the sequencer hold. Coefficients are Q2.30 by
// default, delays are 48-bit Q9.39 and persist until reset.
module biquad_highpass_filter_top #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bhp_in_if.sink                        in_i,
  bhp_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bhp_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bhp_pkg::DATA_BITS-1:0] pwdata,
  output logic [bhp_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int PW    = SAMPLE_BITS + bhp_pkg::COEF_BITS;
  localparam int SH    = (SAMPLE_BITS - 1) + COEF_FRAC_BITS - bhp_pkg::DELAY_FRAC_BITS;
  localparam int SHR   = (SH > 0) ? SH : 0;
  localparam int SHL   = (SH > 0) ? 0 : -SH;
  localparam int AW    = PW - SH;
  localparam int MW0   = (AW > bhp_pkg::DELAY_BITS) ? AW : bhp_pkg::DELAY_BITS;
  localparam int ACC_W = ((MW0 > PW) ? MW0 : PW) + 3;
  localparam int OSH   = bhp_pkg::DELAY_FRAC_BITS - (SAMPLE_BITS - 1);

  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
  localparam logic signed [ACC_W-1:0] D_MAX =
    {{(ACC_W - bhp_pkg::DELAY_BITS + 1){1'b0}}, {(bhp_pkg::DELAY_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] D_MIN = ~D_MAX;
  localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << (OSH - 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_M0   = 8'b0000_0010,
    S_A0   = 8'b0000_0100,
    S_Y    = 8'b0000_1000,
    S_M3   = 8'b0001_0000,
    S_A3   = 8'b0010_0000,
    S_A4   = 8'b0100_0000,
    S_D    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  bhp_pkg::coef_t coef_q [bhp_pkg::NUM_COEFS];

  logic signed [SAMPLE_BITS-1:0]          x_q, x_d, y_q, y_d;
  logic                                   blk_q, blk_d;
  logic signed [PW-1:0]                   prod_q, prod_d;
  logic signed [ACC_W-1:0]                acc_q, acc_d, acc2_q, acc2_d;
  logic signed [bhp_pkg::DELAY_BITS-1:0]  d1_q, d1_d, d2_q, d2_d;
  logic                                   out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0]          out_sample_q, out_sample_d;
  logic                                   out_blk_q, out_blk_d;

  logic signed [SAMPLE_BITS-1:0]   mul_a;
  bhp_pkg::coef_t                  mul_b;
  logic signed [ACC_W-1:0]         aligned, rounded, d1_ext, d2_ext;
  logic signed [ACC_W-1:0]         sat_d1, sat_d2;
  logic signed [SAMPLE_BITS-1:0]   y_sat;
  logic                            in_acc, out_acc, cfg_wr, res_free;
  bhp_pkg::coef_idx_e              cfg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = bhp_pkg::coef_idx_e'(paddr[bhp_pkg::ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[bhp_pkg::REG_FEED_0] <= bhp_pkg::FEED_0_RST;
      coef_q[bhp_pkg::REG_FEED_1] <= bhp_pkg::FEED_1_RST;
      coef_q[bhp_pkg::REG_FEED_2] <= bhp_pkg::FEED_2_RST;
      coef_q[bhp_pkg::REG_BACK_1] <= bhp_pkg::BACK_1_RST;
      coef_q[bhp_pkg::REG_BACK_2] <= bhp_pkg::BACK_2_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bhp_pkg::REG_FEED_0: coef_q[bhp_pkg::REG_FEED_0] <= pwdata;
        bhp_pkg::REG_FEED_1: coef_q[bhp_pkg::REG_FEED_1] <= pwdata;
        bhp_pkg::REG_FEED_2: coef_q[bhp_pkg::REG_FEED_2] <= pwdata;
        bhp_pkg::REG_BACK_1: coef_q[bhp_pkg::REG_BACK_1] <= pwdata;
        bhp_pkg::REG_BACK_2: coef_q[bhp_pkg::REG_BACK_2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bhp_pkg::REG_FEED_0: prdata = coef_q[bhp_pkg::REG_FEED_0];
      bhp_pkg::REG_FEED_1: prdata = coef_q[bhp_pkg::REG_FEED_1];
      bhp_pkg::REG_FEED_2: prdata = coef_q[bhp_pkg::REG_FEED_2];
      bhp_pkg::REG_BACK_1: prdata = coef_q[bhp_pkg::REG_BACK_1];
      bhp_pkg::REG_BACK_2: prdata = coef_q[bhp_pkg::REG_BACK_2];
      default:             prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign in_i.ready          = (state_q == S_IDLE);
  assign in_acc              = in_i.valid && in_i.ready;
  assign out_acc             = out_valid_q && out_o.ready;
  assign res_free            = !out_valid_q || out_o.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.sample_out    = out_sample_q;
  assign out_o.block_end_out = out_blk_q;

  // product aligned to the delay format: floor shift right or exact shift left
  assign aligned = ((ACC_W'(prod_q)) <<< SHL) >>> SHR;
  assign d1_ext  = ACC_W'(d1_q);
  assign d2_ext  = ACC_W'(d2_q);
  assign rounded = (acc_q + RND) >>> OSH;

  always_comb begin
    if (rounded > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    end else if (rounded < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_sat = rounded[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    if (acc_q > D_MAX) begin
      sat_d1 = D_MAX;
    end else if (acc_q < D_MIN) begin
      sat_d1 = D_MIN;
    end else begin
      sat_d1 = acc_q;
    end
    if (acc2_q > D_MAX) begin
      sat_d2 = D_MAX;
    end else if (acc2_q < D_MIN) begin
      sat_d2 = D_MIN;
    end else begin
      sat_d2 = acc2_q;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = x_q;
    mul_b = coef_q[bhp_pkg::REG_FEED_0];
    unique case (state_q)
      S_A0: mul_b = coef_q[bhp_pkg::REG_FEED_1];
      S_Y:  mul_b = coef_q[bhp_pkg::REG_FEED_2];
      S_M3: begin
        mul_a = y_q;
        mul_b = coef_q[bhp_pkg::REG_BACK_1];
      end
      S_A3: begin
        mul_a = y_q;
        mul_b = coef_q[bhp_pkg::REG_BACK_2];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    blk_d        = blk_q;
    y_d          = y_q;
    acc_d        = acc_q;
    acc2_d       = acc2_q;
    d1_d         = d1_q;
    d2_d         = d2_q;
    prod_d       = PW'(mul_a * mul_b);
    out_valid_d  = out_valid_q && !out_acc;
    out_sample_d = out_sample_q;
    out_blk_d    = out_blk_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_d     = in_i.sample_in;
          blk_d   = in_i.block_end_in;
          state_d = S_M0;
        end
      end
      S_M0: state_d = S_A0;
      S_A0: begin
        acc_d   = aligned + d1_ext;
        state_d = S_Y;
      end
      S_Y: begin
        y_d     = y_sat;
        acc_d   = aligned + d2_ext;
        state_d = S_M3;
      end
      S_M3: begin
        acc2_d  = aligned;
        state_d = S_A3;
      end
      S_A3: begin
        acc_d   = acc_q - aligned;
        state_d = S_A4;
      end
      S_A4: begin
        acc2_d  = acc2_q - aligned;
        d1_d    = sat_d1[bhp_pkg::DELAY_BITS-1:0];
        state_d = S_D;
      end
      S_D: begin
        // hold here while the previous result is still waiting
        if (res_free) begin
          d2_d         = sat_d2[bhp_pkg::DELAY_BITS-1:0];
          out_valid_d  = 1'b1;
          out_sample_d = y_q;
          out_blk_d    = blk_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      d1_q        <= d1_d;
      d2_q        <= d2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    blk_q        <= blk_d;
    y_q          <= y_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    acc2_q       <= acc2_d;
    out_sample_q <= out_sample_d;
    out_blk_q    <= out_blk_d;
  end

  // ---------------- assertions ----------------
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_M0) && !in_i.ready)
    else $error("accepted item did not start the sequence");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_D))
    else $error("result appeared outside the final step");

  a_delay_one_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(d1_q) |-> $past(state_q == S_A4))
    else $error("first delay changed outside its update step");

  a_delay_two_upd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(d2_q) |-> $past(state_q == S_D) && $rose(out_valid_q) || $past(out_acc))
    else $error("second delay changed without a result being issued");

endmodule
